// ===== hw/rtl/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear probe hash table
// Table geometry, slot entry layout, operation and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  // Table geometry; the depth must be a power of two
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned FILL_W      = IDX_W + 1;

  // Field widths of the stream payloads
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned KEY_W      = 32;
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned MAX_FILL_W = 8;

  localparam int unsigned IN_BITS  = ACTION_W + KEY_W + HASH_W + VALUE_W;
  localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS = STATUS_W + VALUE_W + SLOT_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [MAX_FILL_W-1:0] MAX_FILL_RST = MAX_FILL_W'(192);

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW     = 3'd0,
    ST_UPDATED = 3'd1,
    ST_FOUND   = 3'd2,
    ST_MISSING = 3'd3,
    ST_DELETED = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  // Stored slot kind; an empty slot is marked by a clear valid bit
  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_USED  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_e;

  typedef struct packed {
    slot_state_e           state;
    logic [KEY_W-1:0]      key;
    logic [VALUE_W-1:0]    value;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_PROBE,
    FSM_FINISH
  } fsm_e;

endpackage

`default_nettype wire

// ===== hw/rtl/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/linear_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressing hash table, linear probing
// Insert, lookup and delete of 32-bit keys with 64-bit values, tombstones.
// ----------------------------------------------------------------------------
// Usage:
//   Operations enter on the s_axis channel (action, key_id, key_hash,
//   value_in) and each gives exactly one result beat on m_axis (status,
//   value_out, slot_index). max_fill is written over the cfg channel, which
//   is always ready; write it only while no operation is in flight.
//   Sequence: an accept step in the idle state that issues the first slot
//   read of a probe, one probe step per slot visited (1 to TABLE_DEPTH
//   slots, each one read of the slot RAM), and a finish step that commits
//   the write and loads the output register; an unused action skips the
//   probe. One operation is in work at a time: s_axis tready is high only
//   in the idle state.
//   The result sits in an output register; while the receiver stalls, the
//   next operation may be accepted and probed, and it waits in its finish
//   state until the register is free.
//   Reset clears all slot valid bits at once (every slot reads as empty),
//   the fill count, and sets max_fill to 192. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Operation stream
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [1:0] action, [33:2] key_id, [65:34] key_hash, [129:66] value_in
  input  wire logic [lpht_pkg::IN_W-1:0]    s_axis_tdata_i,
  // Result stream
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // [2:0] status, [66:3] value_out, [74:67] slot_index
  output logic      [lpht_pkg::OUT_W-1:0]   m_axis_tdata_o,
  // Configuration: max_fill
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [lpht_pkg::MAX_FILL_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = lpht_pkg::IDX_W;

  // Input field split
  lpht_pkg::action_e                in_action;
  logic [lpht_pkg::KEY_W-1:0]       in_key;
  logic [lpht_pkg::HASH_W-1:0]      in_hash;
  logic [lpht_pkg::VALUE_W-1:0]     in_value;

  assign in_action = lpht_pkg::action_e'(s_axis_tdata_i[1:0]);
  assign in_key    = s_axis_tdata_i[33:2];
  assign in_hash   = s_axis_tdata_i[65:34];
  assign in_value  = s_axis_tdata_i[129:66];

  // Control state
  lpht_pkg::fsm_e                   state_q, state_d;
  logic [lpht_pkg::TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [lpht_pkg::FILL_W-1:0]      fill_q, fill_d;
  logic [lpht_pkg::MAX_FILL_W-1:0]  max_fill_q;
  logic                             out_valid_q, out_valid_d;

  // Operation and probe registers
  lpht_pkg::action_e                action_q, action_d;
  logic [lpht_pkg::KEY_W-1:0]       key_q, key_d;
  logic [lpht_pkg::VALUE_W-1:0]     value_q, value_d;
  logic [IDX_W-1:0]                 idx_q, idx_d;
  logic [IDX_W-1:0]                 cnt_q, cnt_d;
  logic                             have_tomb_q, have_tomb_d;
  logic [IDX_W-1:0]                 tomb_q, tomb_d;
  logic                             rd_valid_q, rd_valid_d;

  // Pending commit and result
  logic                             wr_en_q, wr_en_d;
  logic [IDX_W-1:0]                 wr_addr_q, wr_addr_d;
  lpht_pkg::entry_t                 wr_data_q, wr_data_d;
  logic                             fill_inc_q, fill_inc_d;
  lpht_pkg::status_e                res_status_q, res_status_d;
  logic [lpht_pkg::VALUE_W-1:0]     res_value_q, res_value_d;
  logic [lpht_pkg::SLOT_W-1:0]      res_slot_q, res_slot_d;

  // Output register
  lpht_pkg::status_e                out_status_q, out_status_d;
  logic [lpht_pkg::VALUE_W-1:0]     out_value_q, out_value_d;
  logic [lpht_pkg::SLOT_W-1:0]      out_slot_q, out_slot_d;

  // Handshake and RAM port signals
  logic                             in_beat;
  logic                             out_free;
  logic                             action_ok;
  logic                             rd_en;
  logic [IDX_W-1:0]                 rd_addr;
  logic                             ram_we;
  logic [lpht_pkg::ENTRY_W-1:0]     rd_raw;
  lpht_pkg::entry_t                 rd_entry;

  // Probe evaluation
  lpht_pkg::slot_state_e            cur_state;
  logic                             is_hit;
  logic                             is_empty;
  logic                             is_tomb;
  logic                             is_last;
  logic                             probe_end;
  logic                             tomb_seen;
  logic [IDX_W-1:0]                 tomb_pos;
  logic                             spot_ok;
  logic                             spot_empty;
  logic [IDX_W-1:0]                 spot;
  logic                             over_fill;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign action_ok = (in_action == lpht_pkg::ACT_INSERT) ||
                     (in_action == lpht_pkg::ACT_LOOKUP) ||
                     (in_action == lpht_pkg::ACT_DELETE);
  assign rd_entry  = lpht_pkg::entry_t'(rd_raw);
  assign ram_we    = (state_q == lpht_pkg::FSM_FINISH) && out_free && wr_en_q;

  // Slot RAM: key, value and kind of each slot
  lpht_ram #(
    .WIDTH (lpht_pkg::ENTRY_W),
    .DEPTH (lpht_pkg::TABLE_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr_q),
    .wdata_i (wr_data_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_raw)
  );

  // Classify the slot just read; a clear valid bit means empty
  always_comb begin
    cur_state  = rd_valid_q ? rd_entry.state : lpht_pkg::SLOT_EMPTY;
    is_hit     = (cur_state == lpht_pkg::SLOT_USED) && (rd_entry.key == key_q);
    is_tomb    = (cur_state == lpht_pkg::SLOT_TOMB);
    is_empty   = !is_hit && !is_tomb && (cur_state != lpht_pkg::SLOT_USED);
    is_last    = (cnt_q == {IDX_W{1'b1}});
    probe_end  = is_hit || is_empty || is_last;
    tomb_seen  = have_tomb_q || is_tomb;
    tomb_pos   = have_tomb_q ? tomb_q : idx_q;
    spot_ok    = is_empty || tomb_seen;
    spot_empty = is_empty && !have_tomb_q;
    spot       = tomb_seen ? tomb_pos : idx_q;
    over_fill  = 32'(fill_q) >= 32'(max_fill_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lpht_pkg::FSM_IDLE: begin
        if (in_beat) begin
          state_d = action_ok ? lpht_pkg::FSM_PROBE : lpht_pkg::FSM_FINISH;
        end
      end
      lpht_pkg::FSM_PROBE: begin
        if (probe_end) begin
          state_d = lpht_pkg::FSM_FINISH;
        end
      end
      lpht_pkg::FSM_FINISH: begin
        if (out_free) begin
          state_d = lpht_pkg::FSM_IDLE;
        end
      end
      default: state_d = lpht_pkg::FSM_IDLE;
    endcase
  end

  // Sequencer outputs: input ready and slot reads
  always_comb begin
    s_axis_tready_o = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = idx_q + IDX_W'(1);
    unique case (state_q)
      lpht_pkg::FSM_IDLE: begin
        s_axis_tready_o = 1'b1;
        rd_en           = s_axis_tvalid_i && action_ok;
        rd_addr         = in_hash[IDX_W-1:0];
      end
      lpht_pkg::FSM_PROBE: begin
        rd_en = !probe_end;
      end
      lpht_pkg::FSM_FINISH: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Datapath: latch the operation, walk the probe, resolve the result
  always_comb begin
    action_d     = action_q;
    key_d        = key_q;
    value_d      = value_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    have_tomb_d  = have_tomb_q;
    tomb_d       = tomb_q;
    rd_valid_d   = rd_valid_q;
    wr_en_d      = wr_en_q;
    wr_addr_d    = wr_addr_q;
    wr_data_d    = wr_data_q;
    fill_inc_d   = fill_inc_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    res_slot_d   = res_slot_q;

    if (rd_en) begin
      rd_valid_d = valid_q[rd_addr];
    end

    if (state_q == lpht_pkg::FSM_IDLE && in_beat) begin
      // Start a new operation
      action_d     = in_action;
      key_d        = in_key;
      value_d      = in_value;
      idx_d        = in_hash[IDX_W-1:0];
      cnt_d        = '0;
      have_tomb_d  = 1'b0;
      tomb_d       = '0;
      wr_en_d      = 1'b0;
      fill_inc_d   = 1'b0;
      res_status_d = lpht_pkg::ST_MISSING;
      res_value_d  = '0;
      res_slot_d   = '0;
    end else if (state_q == lpht_pkg::FSM_PROBE) begin
      if (!probe_end) begin
        // Advance to the next slot
        idx_d       = idx_q + IDX_W'(1);
        cnt_d       = cnt_q + IDX_W'(1);
        have_tomb_d = tomb_seen;
        tomb_d      = tomb_pos;
      end else if (is_hit) begin
        res_slot_d = lpht_pkg::SLOT_W'(idx_q);
        wr_addr_d  = idx_q;
        unique case (action_q)
          lpht_pkg::ACT_INSERT: begin
            res_status_d = lpht_pkg::ST_UPDATED;
            wr_en_d      = 1'b1;
            wr_data_d    = '{state: lpht_pkg::SLOT_USED, key: key_q, value: value_q};
          end
          lpht_pkg::ACT_LOOKUP: begin
            res_status_d = lpht_pkg::ST_FOUND;
            res_value_d  = rd_entry.value;
          end
          default: begin
            res_status_d = lpht_pkg::ST_DELETED;
            wr_en_d      = 1'b1;
            wr_data_d    = '{state: lpht_pkg::SLOT_TOMB, key: rd_entry.key,
                             value: rd_entry.value};
          end
        endcase
      end else if (action_q == lpht_pkg::ACT_INSERT) begin
        // Key absent: take the first tombstone, else the empty slot if fill is below max_fill, else full
        if (!spot_ok || (spot_empty && over_fill)) begin
          res_status_d = lpht_pkg::ST_FULL;
        end else begin
          res_status_d = lpht_pkg::ST_NEW;
          res_slot_d   = lpht_pkg::SLOT_W'(spot);
          wr_en_d      = 1'b1;
          wr_addr_d    = spot;
          wr_data_d    = '{state: lpht_pkg::SLOT_USED, key: key_q, value: value_q};
          fill_inc_d   = spot_empty;
        end
      end
    end
  end

  // Commit and output load
  always_comb begin
    valid_d      = valid_q;
    fill_d       = fill_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_slot_d   = out_slot_q;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == lpht_pkg::FSM_FINISH && out_free) begin
      if (wr_en_q) begin
        valid_d[wr_addr_q] = 1'b1;
      end
      if (fill_inc_q) begin
        fill_d = fill_q + lpht_pkg::FILL_W'(1);
      end
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_value_d  = res_value_q;
      out_slot_d   = res_slot_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lpht_pkg::FSM_IDLE;
      valid_q     <= '0;
      fill_q      <= '0;
      max_fill_q  <= lpht_pkg::MAX_FILL_RST;
      out_valid_q <= 1'b0;
      wr_en_q     <= 1'b0;
      fill_inc_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      wr_en_q     <= wr_en_d;
      fill_inc_q  <= fill_inc_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_fill_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    action_q     <= action_d;
    key_q        <= key_d;
    value_q      <= value_d;
    idx_q        <= idx_d;
    cnt_q        <= cnt_d;
    have_tomb_q  <= have_tomb_d;
    tomb_q       <= tomb_d;
    rd_valid_q   <= rd_valid_d;
    wr_addr_q    <= wr_addr_d;
    wr_data_q    <= wr_data_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_slot_q   <= out_slot_d;
  end

  // Ports
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(lpht_pkg::OUT_W - lpht_pkg::OUT_BITS)'(0),
                            out_slot_q, out_value_q, out_status_q};

  // Checks
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= lpht_pkg::TABLE_DEPTH)
    else $error("fill count beyond table depth");

  a_fill_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> ($past(state_q) == lpht_pkg::FSM_FINISH))
    else $error("fill count changed outside commit");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpht_pkg::FSM_FINISH && out_free) |=> out_valid_q)
    else $error("finished operation produced no result beat");

  a_no_read_in_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lpht_pkg::FSM_FINISH) |-> !rd_en && !s_axis_tready_o)
    else $error("slot read or accept during commit");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for linear_probe_hash_table_unit
// Drives insert, lookup, delete and unused operations on the operation stream
// and keeps its own shadow of the slot store, the fill count and max_fill.
// Every result beat is compared field by field with the oldest prediction.
// A directed table comes first: the empty table, wrap-around, key zero,
// tombstone skip and reuse, updates, and the table-full cases. Random phases
// follow, each at its own max_fill setting, with collision-heavy key sets and
// random stalls on both streams in all but the last phase.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lpht_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
  } reply_t;

  typedef enum logic {ROW_OP, ROW_CFG} row_kind_e;

  // One row of the directed table; a config row carries max_fill in value
  typedef struct packed {
    row_kind_e          kind;
    action_e            act;
    logic [KEY_W-1:0]   key;
    logic [HASH_W-1:0]  hash;
    logic [VALUE_W-1:0] value;
    logic               known;
    reply_t             reply;
  } row_t;

  localparam int unsigned NUM_ROWS   = 24;
  localparam int unsigned POOL_SIZE  = 64;
  localparam int unsigned NUM_PHASES = 4;
  localparam int unsigned PHASE_OPS  = 400;

  localparam row_t DIRECTED [NUM_ROWS] = '{
    // Empty table: nothing to find or delete
    '{ROW_OP, ACT_LOOKUP, 32'h0000_0005, 32'h0000_0000, 64'h0, 1'b1,
      '{ST_MISSING, 64'h0, 8'd0}},
    '{ROW_OP, ACT_DELETE, 32'h0000_0005, 32'h0000_0000, 64'h0, 1'b1,
      '{ST_MISSING, 64'h0, 8'd0}},
    // Fill the last slot, then wrap into slots 0 and 1
    '{ROW_OP, ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
      '{ST_NEW, 64'h0, 8'd255}},
    '{ROW_OP, ACT_INSERT, 32'h0000_0001, 32'hFFFF_FFFF, 64'h0, 1'b1,
      '{ST_NEW, 64'h0, 8'd0}},
    // Key zero behaves as any other key
    '{ROW_OP, ACT_INSERT, 32'h0000_0000, 32'h0000_00FF, 64'h0123_4567_89AB_CDEF, 1'b1,
      '{ST_NEW, 64'h0, 8'd1}},
    '{ROW_OP, ACT_LOOKUP, 32'h0000_0000, 32'h0000_00FF, 64'h0, 1'b1,
      '{ST_FOUND, 64'h0123_4567_89AB_CDEF, 8'd1}},
    '{ROW_OP, ACT_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 1'b1,
      '{ST_FOUND, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255}},
    // Update of a present key
    '{ROW_OP, ACT_INSERT, 32'h0000_0001, 32'hFFFF_FFFF, 64'hDEAD_BEEF_0000_0001, 1'b1,
      '{ST_UPDATED, 64'h0, 8'd0}},
    '{ROW_OP, ACT_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF, 64'h0, 1'b1,
      '{ST_FOUND, 64'hDEAD_BEEF_0000_0001, 8'd0}},
    // Tombstone in slot 255: lookup skips it, a new key reuses it
    '{ROW_OP, ACT_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0, 1'b1,
      '{ST_DELETED, 64'h0, 8'd255}},
    '{ROW_OP, ACT_LOOKUP, 32'h0000_0001, 32'hFFFF_FFFF, 64'h0, 1'b1,
      '{ST_FOUND, 64'hDEAD_BEEF_0000_0001, 8'd0}},
    '{ROW_OP, ACT_INSERT, 32'h0000_0007, 32'h0000_00FF, 64'h8000_0000_0000_0000, 1'b1,
      '{ST_NEW, 64'h0, 8'd255}},
    '{ROW_OP, ACT_LOOKUP, 32'h0000_0007, 32'h0000_00FF, 64'h0, 1'b1,
      '{ST_FOUND, 64'h8000_0000_0000_0000, 8'd255}},
    // Unused action changes nothing
    '{ROW_OP, ACT_NONE, 32'h0000_0001, 32'hFFFF_FFFF, 64'h5A5A_A5A5_5A5A_A5A5, 1'b1,
      '{ST_MISSING, 64'h0, 8'd0}},
    // Delete by a different hash that still starts on the key's slot
    '{ROW_OP, ACT_DELETE, 32'h0000_0001, 32'h1234_5600, 64'h0, 1'b1,
      '{ST_DELETED, 64'h0, 8'd0}},
    '{ROW_OP, ACT_DELETE, 32'h0000_0001, 32'h1234_5600, 64'h0, 1'b1,
      '{ST_MISSING, 64'h0, 8'd0}},
    '{ROW_OP, ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 64'h0, 1'b1,
      '{ST_FOUND, 64'h0123_4567_89AB_CDEF, 8'd1}},
    '{ROW_OP, ACT_INSERT, 32'h8000_0000, 32'h8000_0080, 64'hFEDC_BA98_7654_3210, 1'b0,
      '{ST_NEW, 64'h0, 8'd0}},
    // max_fill of zero: no empty slot may be taken, updates and reuse still go
    '{ROW_CFG, ACT_NONE, 32'h0, 32'h0, 64'd0, 1'b0, '{ST_MISSING, 64'h0, 8'd0}},
    '{ROW_OP, ACT_INSERT, 32'h0000_0055, 32'h0000_0040, 64'h1, 1'b1,
      '{ST_FULL, 64'h0, 8'd0}},
    '{ROW_OP, ACT_INSERT, 32'h0000_0000, 32'h0000_00FF, 64'h1111_2222_3333_4444, 1'b1,
      '{ST_UPDATED, 64'h0, 8'd1}},
    '{ROW_OP, ACT_INSERT, 32'h0000_AAAA, 32'h0000_0100, 64'h2, 1'b1,
      '{ST_NEW, 64'h0, 8'd0}},
    // Highest limit: an empty slot is taken again
    '{ROW_CFG, ACT_NONE, 32'h0, 32'h0, 64'd255, 1'b0, '{ST_MISSING, 64'h0, 8'd0}},
    '{ROW_OP, ACT_INSERT, 32'h5555_AAAA, 32'h0000_0040, 64'h3, 1'b1,
      '{ST_NEW, 64'h0, 8'd64}}
  };

  localparam logic [MAX_FILL_W-1:0] PHASE_FILL [NUM_PHASES] = '{8'd1, 8'd48, 8'd120, 8'd255};
  localparam int unsigned PHASE_SEND_IDLE [NUM_PHASES] = '{29, 29, 48, 0};
  localparam int unsigned PHASE_RECV_IDLE [NUM_PHASES] = '{48, 48, 29, 0};

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [MAX_FILL_W-1:0] cfg_data  = '0;

  // Shadow of the table
  slot_state_e           tbl_state [TABLE_DEPTH];
  logic [KEY_W-1:0]      tbl_key   [TABLE_DEPTH];
  logic [VALUE_W-1:0]    tbl_value [TABLE_DEPTH];
  int unsigned           fill_now;
  logic [MAX_FILL_W-1:0] fill_limit;

  reply_t                pending_replies [$];
  int unsigned           mismatches    = 0;
  int unsigned           send_idle_pct = 0;
  int unsigned           recv_idle_pct = 0;

  logic [KEY_W-1:0]      pool_key  [POOL_SIZE];
  logic [HASH_W-1:0]     pool_hash [POOL_SIZE];

  linear_probe_hash_table_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one operation to the shadow table and return its result
  function automatic reply_t table_apply(action_e act, logic [KEY_W-1:0] key,
                                         logic [HASH_W-1:0] hash,
                                         logic [VALUE_W-1:0] value);
    reply_t      r;
    int unsigned idx, n, hit_at, tomb_at, spot;
    bit          hit, have_tomb, spot_ok, spot_empty, done;
    r.status   = ST_MISSING;
    r.value    = '0;
    r.slot     = '0;
    hit        = 1'b0;
    have_tomb  = 1'b0;
    spot_ok    = 1'b0;
    spot_empty = 1'b0;
    done       = 1'b0;
    hit_at     = 0;
    tomb_at    = 0;
    spot       = 0;
    if (act == ACT_NONE) return r;

    // Walk from the home slot; stop on the key or on an empty slot
    idx = hash & (TABLE_DEPTH - 1);
    for (n = 0; n < TABLE_DEPTH && !done; n++) begin
      case (tbl_state[idx])
        SLOT_USED: begin
          if (tbl_key[idx] == key) begin
            hit    = 1'b1;
            hit_at = idx;
            done   = 1'b1;
          end
        end
        SLOT_TOMB: begin
          if (!have_tomb) begin
            have_tomb = 1'b1;
            tomb_at   = idx;
          end
        end
        default: begin
          spot_ok    = 1'b1;
          spot       = have_tomb ? tomb_at : idx;
          spot_empty = !have_tomb;
          done       = 1'b1;
        end
      endcase
      idx = (idx + 1) % TABLE_DEPTH;
    end
    if (!hit && !spot_ok && have_tomb) begin
      spot_ok = 1'b1;
      spot    = tomb_at;
    end

    if (act == ACT_INSERT) begin
      if (hit) begin
        tbl_value[hit_at] = value;
        r.status          = ST_UPDATED;
        r.slot            = SLOT_W'(hit_at);
      end else if (!spot_ok || (spot_empty && fill_now >= fill_limit)) begin
        r.status = ST_FULL;
      end else begin
        if (spot_empty) fill_now++;
        tbl_state[spot] = SLOT_USED;
        tbl_key[spot]   = key;
        tbl_value[spot] = value;
        r.status        = ST_NEW;
        r.slot          = SLOT_W'(spot);
      end
    end else if (hit) begin
      r.slot = SLOT_W'(hit_at);
      if (act == ACT_LOOKUP) begin
        r.status = ST_FOUND;
        r.value  = tbl_value[hit_at];
      end else begin
        tbl_state[hit_at] = SLOT_TOMB;
        r.status          = ST_DELETED;
      end
    end
    return r;
  endfunction

  // Send one operation beat; a known result replaces the shadow's one
  task automatic issue_op(action_e act, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash,
                          logic [VALUE_W-1:0] value, logic known, reply_t typed);
    reply_t want;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - IN_BITS){1'b0}}, value, hash, key, act};
    do @(posedge clk_i); while (!s_tready);
    want = table_apply(act, key, hash, value);
    pending_replies.push_back(known ? typed : want);
  endtask

  // Hold the operation stream until every result is back
  task automatic wait_replies_drained();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_max_fill(logic [MAX_FILL_W-1:0] limit);
    wait_replies_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk_i); while (!cfg_ready);
    fill_limit = limit;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stalls
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_replies
    reply_t              want;
    logic [STATUS_W-1:0] got_status;
    logic [VALUE_W-1:0]  got_value;
    logic [SLOT_W-1:0]   got_slot;
    if (rst_ni && m_tvalid && m_tready) begin
      got_status = m_tdata[STATUS_W-1:0];
      got_value  = m_tdata[STATUS_W +: VALUE_W];
      got_slot   = m_tdata[STATUS_W + VALUE_W +: SLOT_W];
      if (pending_replies.size() == 0) begin
        $error("result beat with no operation outstanding: status %0d", got_status);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (got_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got_status);
          mismatches++;
        end
        if (got_value !== want.value) begin
          $error("value_out: expected %h, got %h", want.value, got_value);
          mismatches++;
        end
        if (got_slot !== want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, got_slot);
          mismatches++;
        end
      end
    end
  end

  initial begin : drive
    row_t              row;
    int unsigned       i, p, n, pick, entry;
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    action_e           act;

    for (i = 0; i < TABLE_DEPTH; i++) begin
      tbl_state[i] = SLOT_EMPTY;
      tbl_key[i]   = '0;
      tbl_value[i] = '0;
    end
    fill_now   = 0;
    fill_limit = MAX_FILL_RST;

    // Half the keys crowd a few home slots around the wrap point
    for (i = 0; i < POOL_SIZE; i++) begin
      pool_key[i]  = $urandom;
      pool_hash[i] = $urandom;
      if (i % 2 == 0) pool_hash[i][7:0] = 8'(250 + $urandom_range(11));
    end

    send_idle_pct = PHASE_SEND_IDLE[0];
    recv_idle_pct = PHASE_RECV_IDLE[0];
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    for (i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_CFG) begin
        write_max_fill(row.value[MAX_FILL_W-1:0]);
      end else begin
        issue_op(row.act, row.key, row.hash, row.value, row.known, row.reply);
      end
    end

    // Random phases, one max_fill setting each
    for (p = 0; p < NUM_PHASES; p++) begin
      write_max_fill(PHASE_FILL[p]);
      send_idle_pct = PHASE_SEND_IDLE[p];
      recv_idle_pct = PHASE_RECV_IDLE[p];
      for (n = 0; n < PHASE_OPS; n++) begin
        if ($urandom_range(199) == 0) wait_replies_drained();
        entry = $urandom_range(POOL_SIZE - 1);
        key   = pool_key[entry];
        hash  = pool_hash[entry];
        pick  = $urandom_range(99);
        if (pick < 8) begin
          key  = $urandom;
          hash = $urandom;
        end else if (pick < 12) begin
          hash = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 40)      act = ACT_INSERT;
        else if (pick < 70) act = ACT_LOOKUP;
        else if (pick < 95) act = ACT_DELETE;
        else                act = ACT_NONE;
        issue_op(act, key, hash, {$urandom, $urandom}, 1'b0, '0);
      end
    end

    // Drain, then give a stray beat the time of a full probe to show up
    wait_replies_drained();
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Every operation probing the whole table with both sides stalling fits
  // well inside this bound
  initial begin : watchdog
    #50_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
